[design/laq_pkg.sv]
// ----------------------------------------------------------------------------
// laq_pkg
// Shared types and codes for the linear array queue.
// ----------------------------------------------------------------------------
`default_nettype none

package laq_pkg;

  localparam int IDX_W  = 5;
  localparam int CAP_W  = 5;
  localparam int DATA_W = 32;
  localparam int CMD_W  = 2;
  localparam int ST_W   = 2;

  localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DISP = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_STATUS,
    OP_WRITE,
    OP_READ,
    OP_DISPLAY
  } op_kind_t;

  typedef struct packed {
    op_kind_t              kind;
    logic [ST_W-1:0]       status;
    logic [IDX_W-1:0]      idx_a;
    logic [IDX_W-1:0]      idx_b;
    logic signed [DATA_W-1:0] value;
  } op_t;

endpackage

`default_nettype wire

[design/laq_fifo.sv]
// ----------------------------------------------------------------------------
// laq_fifo
// Short operation queue between the command front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module laq_fifo
  import laq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire op_t  push_op,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output op_t       pop_op
);

  localparam int QD   = 4;
  localparam int QA_W = 2;

  op_t              store_r [QD];
  logic [QA_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QA_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QA_W:0]    count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != (QA_W+1)'(QD));
  assign pop_valid  = (count_r != '0);
  assign pop_op     = store_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

`default_nettype wire

[design/laq_front.sv]
// ----------------------------------------------------------------------------
// laq_front
// Command front end: holds queue indices and capacity, classifies commands.
// ----------------------------------------------------------------------------
`default_nettype none

module laq_front
  import laq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CAP_W-1:0]   cfg_data,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [CMD_W-1:0]   in_tuser,
  input  wire logic [DATA_W-1:0]  in_tdata,
  output logic                    push_valid,
  input  wire logic               push_ready,
  output op_t                     push_op
);

  localparam int              CAP_MAX   = (DEPTH < 31) ? DEPTH : 31;
  localparam logic [CAP_W-1:0] CAP_MAX_V = CAP_W'(CAP_MAX);

  logic [CAP_W-1:0] capacity_r;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic             empty_r, empty_nxt;
  logic [CAP_W-1:0] cap;
  logic             full;
  logic             accept;
  op_t              op;

  assign cfg_ready  = 1'b1;
  assign in_tready  = push_ready;
  assign accept     = in_tvalid && push_ready;
  assign push_valid = in_tvalid;
  assign push_op    = op;

  assign cap  = (capacity_r > CAP_MAX_V) ? CAP_MAX_V : capacity_r;
  assign full = (cap == '0) ||
                (!empty_r && (({1'b0, tail_r} + (IDX_W+1)'(1)) >= {1'b0, cap}));

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    empty_nxt = empty_r;
    op.kind   = OP_STATUS;
    op.status = ST_OK;
    op.idx_a  = head_r;
    op.idx_b  = tail_r;
    op.value  = in_tdata;
    if (in_tuser == CMD_ENQ) begin
      if (full) begin
        op.status = ST_FULL;
      end else if (empty_r) begin
        head_nxt  = '0;
        tail_nxt  = '0;
        empty_nxt = 1'b0;
        op.kind   = OP_WRITE;
        op.idx_a  = '0;
      end else begin
        tail_nxt  = tail_r + 1'b1;
        op.kind   = OP_WRITE;
        op.idx_a  = tail_r + 1'b1;
      end
    end else if (empty_r) begin
      op.status = ST_EMPTY;
    end else begin
      case (in_tuser)
        CMD_DEQ: begin
          op.kind = OP_READ;
          if (head_r == tail_r) begin
            head_nxt  = '0;
            tail_nxt  = '0;
            empty_nxt = 1'b1;
          end else begin
            head_nxt = head_r + 1'b1;
          end
        end
        CMD_PEEK: begin
          op.kind = OP_READ;
        end
        default: begin
          op.kind = OP_DISPLAY;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
      head_r     <= '0;
      tail_r     <= '0;
      empty_r    <= 1'b1;
    end else begin
      if (cfg_valid) begin
        capacity_r <= cfg_data;
      end
      if (accept) begin
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        empty_r <= empty_nxt;
      end
    end
  end

endmodule

`default_nettype wire

[design/laq_back.sv]
// ----------------------------------------------------------------------------
// laq_back
// Back end: owns the slot memory, executes queued operations in order and
// streams results through a registered output stage, one per unstalled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module laq_back
  import laq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               op_valid,
  output logic                    op_ready,
  input  wire op_t                op,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [ST_W-1:0]         out_tuser,
  output logic [DATA_W-1:0]       out_tdata,
  output logic                    out_tlast
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] mem [DEPTH];

  logic              out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]   out_status_r, out_status_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_mem_r, out_mem_nxt;
  logic [DATA_W-1:0] rd_data_r;
  logic              disp_busy_r, disp_busy_nxt;
  logic [IDX_W-1:0]  disp_idx_r, disp_idx_nxt;

  logic              adv;
  logic              mem_we;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_idx;

  assign adv        = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = out_mem_r ? rd_data_r : '0;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    out_mem_nxt    = out_mem_r;
    disp_busy_nxt  = disp_busy_r;
    disp_idx_nxt   = disp_idx_r;
    op_ready       = 1'b0;
    mem_we         = 1'b0;
    rd_en          = 1'b0;
    rd_idx         = disp_busy_r ? disp_idx_r : op.idx_a;
    if (adv) begin
      out_valid_nxt  = op_valid;
      out_status_nxt = ST_OK;
      out_last_nxt   = 1'b1;
      out_mem_nxt    = 1'b0;
      if (op_valid) begin
        case (op.kind)
          OP_STATUS: begin
            out_status_nxt = op.status;
            op_ready       = 1'b1;
          end
          OP_WRITE: begin
            mem_we   = 1'b1;
            op_ready = 1'b1;
          end
          OP_READ: begin
            rd_en       = 1'b1;
            out_mem_nxt = 1'b1;
            op_ready    = 1'b1;
          end
          default: begin
            rd_en        = 1'b1;
            out_mem_nxt  = 1'b1;
            out_last_nxt = (rd_idx == op.idx_b);
            if (rd_idx == op.idx_b) begin
              op_ready      = 1'b1;
              disp_busy_nxt = 1'b0;
            end else begin
              disp_busy_nxt = 1'b1;
              disp_idx_nxt  = rd_idx + 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      out_status_r <= ST_OK;
      out_last_r   <= 1'b0;
      out_mem_r    <= 1'b0;
      disp_busy_r  <= 1'b0;
      disp_idx_r   <= '0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
      out_last_r   <= out_last_nxt;
      out_mem_r    <= out_mem_nxt;
      disp_busy_r  <= disp_busy_nxt;
      disp_idx_r   <= disp_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(op.idx_a)] <= op.value;
    end
    if (rd_en) begin
      rd_data_r <= mem[AW'(rd_idx)];
    end
  end

endmodule

`default_nettype wire

[design/linear_array_queue.sv]
// ----------------------------------------------------------------------------
// linear_array_queue
// Non-circular array queue with enqueue, dequeue, peek and display commands.
// ----------------------------------------------------------------------------
// The back end handles one enqueue, dequeue or peek per cycle, so one such
// command can be accepted per cycle unless stalled; its result passes through
// the operation queue and the output register. Display returns head to tail,
// one element per cycle unless stalled, as the back-end slot memory has a
// single read port. A 4-entry operation queue sits between the command front
// end and the back end, so commands keep being accepted during a display
// until it fills. The queue becomes full once the tail reaches capacity - 1
// and frees its slots only when it drains completely. Capacity above DEPTH
// acts as DEPTH; capacity is a 5-bit register, so at most 31 slots are used.
`default_nettype none

module linear_array_queue
  import laq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CAP_W-1:0]   cfg_data,   // capacity
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [CMD_W-1:0]   in_tuser,   // command
  input  wire logic [DATA_W-1:0]  in_tdata,   // value
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [ST_W-1:0]         out_tuser,  // status
  output logic [DATA_W-1:0]       out_tdata,  // data
  output logic                    out_tlast
);

  logic push_valid, push_ready;
  op_t  push_op;
  logic pop_valid, pop_ready;
  op_t  pop_op;

  laq_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op)
  );

  laq_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  laq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .op_valid   (pop_valid),
    .op_ready   (pop_ready),
    .op         (pop_op),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the linear array queue against its own command-level predictor.
// A driver feeds commands from a queue that the stimulus process fills, and a
// monitor predicts the results of every accepted command and compares each
// returned transfer field by field. The stimulus starts with directed corner
// cases, then runs random phases at several capacities with random idling on
// both sides, one long receiver hold-off, and a full drain between phases.
// ----------------------------------------------------------------------------

module testbench;
  import laq_pkg::*;

  localparam int DEPTH = 16;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] value;
  } queue_cmd_t;

  typedef struct {
    logic [ST_W-1:0]   status;
    logic [DATA_W-1:0] data;
    logic              last;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CAP_W-1:0]  cfg_data = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [CMD_W-1:0]  in_tuser = '0;
  logic [DATA_W-1:0] in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [ST_W-1:0]   out_tuser;
  logic [DATA_W-1:0] out_tdata;
  logic              out_tlast;

  queue_cmd_t    cmd_queue[$];
  queue_result_t awaited_results[$];

  int unsigned queued_count = 0;
  int unsigned accepted_count = 0;
  int unsigned errors = 0;

  // predictor state
  logic [DATA_W-1:0] q_slots [DEPTH];
  int unsigned       q_head = 0;
  int unsigned       q_tail = 0;
  logic              q_empty = 1'b1;
  logic [CAP_W-1:0]  q_capacity = CAP_RESET;

  logic long_hold_armed = 1'b0;
  logic long_hold_done = 1'b0;

  int unsigned tx_wait = 0;
  int unsigned tx_run = 0;
  int unsigned rx_wait = 0;
  int unsigned rx_run = 0;

  linear_array_queue #(.DEPTH(DEPTH)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idle cycles before the next transfer; runs of zero now and then
  function automatic int unsigned idle_cycles(inout int unsigned run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      run_left = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  function automatic void push_result(input logic [ST_W-1:0] status,
                                      input logic [DATA_W-1:0] data,
                                      input logic last);
    queue_result_t r;
    r.status = status;
    r.data = data;
    r.last = last;
    awaited_results.push_back(r);
  endfunction

  function automatic void apply_command(input logic [CMD_W-1:0] cmd,
                                        input logic [DATA_W-1:0] value);
    int unsigned cap;
    int unsigned i;
    int unsigned n;
    cap = (q_capacity > DEPTH) ? DEPTH : q_capacity;
    if (cmd == CMD_ENQ) begin
      if (cap == 0 || (!q_empty && q_tail + 1 >= cap)) begin
        push_result(ST_FULL, '0, 1'b1);
      end else if (q_empty) begin
        q_head = 0;
        q_tail = 0;
        q_slots[0] = value;
        q_empty = 1'b0;
        push_result(ST_OK, '0, 1'b1);
      end else begin
        q_tail++;
        q_slots[q_tail % DEPTH] = value;
        push_result(ST_OK, '0, 1'b1);
      end
    end else if (q_empty) begin
      push_result(ST_EMPTY, '0, 1'b1);
    end else if (cmd == CMD_DEQ) begin
      push_result(ST_OK, q_slots[q_head % DEPTH], 1'b1);
      if (q_head == q_tail) begin
        q_head = 0;
        q_tail = 0;
        q_empty = 1'b1;
      end else begin
        q_head++;
      end
    end else if (cmd == CMD_PEEK) begin
      push_result(ST_OK, q_slots[q_head % DEPTH], 1'b1);
    end else begin
      n = 0;
      for (i = q_head; i <= q_tail && n < DEPTH; i++) begin
        push_result(ST_OK, q_slots[i % DEPTH], (i == q_tail || n == DEPTH - 1));
        n++;
      end
    end
  endfunction

  // command driver
  always @(posedge clk) begin
    queue_cmd_t c;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tuser <= '0;
      in_tdata <= '0;
    end else if (!(in_tvalid && !in_tready)) begin
      if (tx_wait > 0) begin
        tx_wait--;
        in_tvalid <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
        c = cmd_queue.pop_front();
        in_tuser <= c.cmd;
        in_tdata <= c.value;
        in_tvalid <= 1'b1;
        tx_wait = idle_cycles(tx_run);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (long_hold_armed && !long_hold_done) begin
      long_hold_done = 1'b1;
      rx_wait = LONG_HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      rx_wait = idle_cycles(rx_run);
      out_tready <= (rx_wait == 0);
    end else if (!out_tready) begin
      if (rx_wait > 0) rx_wait--;
      out_tready <= (rx_wait == 0);
    end
  end

  // prediction on accepted commands, comparison on returned results
  always @(posedge clk) begin : monitor
    queue_result_t exp_r;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        apply_command(in_tuser, in_tdata);
        accepted_count++;
      end
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result status %0d data %h last %0d",
                   $time, out_tuser, out_tdata, out_tlast);
          errors++;
        end else begin
          exp_r = awaited_results.pop_front();
          if (out_tuser !== exp_r.status) begin
            $display("%0t: status expected %0d got %0d", $time, exp_r.status, out_tuser);
            errors++;
          end
          if (out_tdata !== exp_r.data) begin
            $display("%0t: data expected %h got %h", $time, exp_r.data, out_tdata);
            errors++;
          end
          if (out_tlast !== exp_r.last) begin
            $display("%0t: last expected %0d got %0d", $time, exp_r.last, out_tlast);
            errors++;
          end
        end
      end
    end
  end

  task automatic send(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value);
    queue_cmd_t c;
    c.cmd = cmd;
    c.value = value;
    cmd_queue.push_back(c);
    queued_count++;
  endtask

  task automatic drain();
    while (accepted_count != queued_count || awaited_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    @(posedge clk);
    cfg_data <= cap;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    q_capacity = cap;
  endtask

  task automatic random_phase(input int unsigned n_items, input int unsigned enq_pct);
    int unsigned r;
    logic [CMD_W-1:0] cmd;
    logic [DATA_W-1:0] value;
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      if (r < enq_pct) cmd = CMD_ENQ;
      else if (r < enq_pct + (100 - enq_pct) / 2) cmd = CMD_DEQ;
      else if (r < enq_pct + 3 * (100 - enq_pct) / 4) cmd = CMD_PEEK;
      else cmd = CMD_DISP;
      case ($urandom_range(0, 15))
        0: value = 32'h7fff_ffff;
        1: value = 32'h8000_0000;
        2: value = 32'h0000_0000;
        3: value = 32'hffff_ffff;
        default: value = $urandom;
      endcase
      send(cmd, value);
    end
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // empty queue, extreme values, peek, display, dequeue
    send(CMD_DEQ, 32'h0);
    send(CMD_PEEK, 32'hffff_ffff);
    send(CMD_DISP, 32'h0);
    send(CMD_ENQ, 32'h7fff_ffff);
    send(CMD_ENQ, 32'h8000_0000);
    send(CMD_ENQ, 32'h0000_0000);
    send(CMD_ENQ, 32'hffff_ffff);
    send(CMD_PEEK, 32'h0);
    send(CMD_DISP, 32'h0);
    send(CMD_DEQ, 32'h0);
    drain();

    // capacity dropped below the tail: full until drained
    write_capacity(5'd2);
    send(CMD_ENQ, 32'h1234_5678);
    send(CMD_DISP, 32'h0);
    send(CMD_DEQ, 32'h0);
    send(CMD_DEQ, 32'h0);
    send(CMD_DEQ, 32'h0);
    send(CMD_DEQ, 32'h0);
    send(CMD_ENQ, 32'h0000_0001);
    send(CMD_ENQ, 32'hdead_beef);
    send(CMD_ENQ, 32'h5555_aaaa);
    drain();

    // zero capacity rejects every enqueue
    write_capacity(5'd0);
    send(CMD_ENQ, 32'haaaa_5555);
    send(CMD_PEEK, 32'h0);
    send(CMD_DEQ, 32'h0);
    send(CMD_DEQ, 32'h0);
    send(CMD_ENQ, 32'h0000_0002);
    drain();

    // capacity above the built depth saturates
    write_capacity(5'd31);
    send(CMD_ENQ, 32'h0bad_f00d);
    send(CMD_DEQ, 32'h0);
    drain();

    long_hold_armed <= 1'b1;
    write_capacity(5'd16);
    random_phase(30, 60);
    write_capacity(5'd1);
    random_phase(25, 50);
    write_capacity(5'd31);
    random_phase(25, 55);
    write_capacity(5'($urandom_range(0, 31)));
    random_phase(24, 50);
    write_capacity(5'd3);
    random_phase(20, 45);
    write_capacity(5'd16);
    random_phase(20, 35);

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
